// ===== rtl/prpc_pkg.sv =====
// Shared types, constants and command structs for the wheel speed controller.
package prpc_pkg;

  localparam int unsigned RateW  = 16;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned IntW   = 32;
  localparam int unsigned GainW  = 16;
  localparam int unsigned LimW   = 15;
  localparam int unsigned DivCnt = 17;

  localparam logic [2:0] REG_KP   = 3'd0;
  localparam logic [2:0] REG_KI   = 3'd1;
  localparam logic [2:0] REG_KD   = 3'd2;
  localparam logic [2:0] REG_ILIM = 3'd3;
  localparam logic [2:0] REG_MINS = 3'd4;
  localparam logic [2:0] REG_MAXS = 3'd5;
  localparam logic [2:0] REG_PWMX = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ERR, ST_DIV, ST_DSIGN, ST_IMUL1, ST_IMUL2, ST_ICLAMP,
    ST_PMUL, ST_DMUL, ST_SUM, ST_LEVEL, ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic err;
    logic div_start;
    logic div_step;
    logic dsign;
    logic imul1;
    logic imul2;
    logic iclamp;
    logic pmul;
    logic dmul;
    logic sum;
    logic level;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

// ===== rtl/prpc_ctrl.sv =====
// Sequencer for one control step.
module prpc_ctrl import prpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  logic     out_free,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     res_push
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_fire) state_next = ST_ERR;
      ST_ERR:    state_next = ST_DIV;
      ST_DIV:    if (stat.div_done) state_next = ST_DSIGN;
      ST_DSIGN:  state_next = ST_IMUL1;
      ST_IMUL1:  state_next = ST_IMUL2;
      ST_IMUL2:  state_next = ST_ICLAMP;
      ST_ICLAMP: state_next = ST_PMUL;
      ST_PMUL:   state_next = ST_DMUL;
      ST_DMUL:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_LEVEL;
      ST_LEVEL:  state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    res_push = 1'b0;
    unique case (state)
      ST_IDLE:   cmd.load = in_fire;
      ST_ERR:    begin cmd.err = 1'b1; cmd.div_start = 1'b1; end
      ST_DIV:    cmd.div_step = 1'b1;
      ST_DSIGN:  cmd.dsign = 1'b1;
      ST_IMUL1:  cmd.imul1 = 1'b1;
      ST_IMUL2:  cmd.imul2 = 1'b1;
      ST_ICLAMP: cmd.iclamp = 1'b1;
      ST_PMUL:   cmd.pmul = 1'b1;
      ST_DMUL:   cmd.dmul = 1'b1;
      ST_SUM:    cmd.sum = 1'b1;
      ST_LEVEL:  cmd.level = 1'b1;
      ST_OUT:    res_push = out_free;
      default:   ;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== rtl/prpc_dp.sv =====
// Datapath: error, divider, multiply steps, integral and PWM level.
module prpc_dp import prpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic signed [RateW-1:0] rate_ref,
  input  logic signed [RateW-1:0] rate_est,
  input  logic [15:0]             elapsed_ms,
  input  logic [GainW-1:0]        kp_gain,
  input  logic [GainW-1:0]        ki_gain,
  input  logic [GainW-1:0]        kd_gain,
  input  logic [LimW-1:0]         integral_limit,
  input  logic signed [15:0]      min_step,
  input  logic [14:0]             max_step,
  input  logic [15:0]             pwm_max,
  output logic signed [15:0]      pwm_step,
  output logic [15:0]             pwm_level
);

  logic signed [RateW-1:0] ref_q, est_q;
  logic [15:0]             dt;
  logic signed [ErrW-1:0]  err, last_error;
  logic signed [IntW-1:0]  integral_sum;
  logic [15:0]             duty_level;
  logic [17:0]             rem, quo;
  logic [17:0]             dnum;
  logic                    dneg;
  logic [4:0]              dcnt;
  logic signed [18:0]      de;
  logic signed [33:0]      prod;
  logic signed [33:0]      pterm;
  logic signed [51:0]      iacc;
  logic signed [53:0]      total;
  logic signed [37:0]      trunc_q;
  logic signed [17:0]      step;

  logic [16:0]        abs_ref, abs_est;
  logic signed [18:0] diff;
  logic [18:0]        rem_try;
  logic signed [51:0] ilim, inew;
  logic signed [53:0] tmag;
  logic signed [37:0] trunc;
  logic signed [17:0] lvl;

  assign abs_ref = ref_q[RateW-1] ? 17'(-$signed({ref_q[RateW-1], ref_q}))
                                  : {1'b0, ref_q};
  assign abs_est = est_q[RateW-1] ? 17'(-$signed({est_q[RateW-1], est_q}))
                                  : {1'b0, est_q};
  assign diff    = 19'($signed({1'b0, abs_ref}) - $signed({1'b0, abs_est}))
                 - 19'(last_error);
  assign rem_try = {rem, dnum[17]} - {3'b0, dt};
  assign ilim    = $signed({21'b0, integral_limit, 16'b0});
  assign tmag    = total[53] ? -total : total;
  assign trunc   = total[53] ? -$signed({1'b0, tmag[52:16]}) : $signed({1'b0, tmag[52:16]});

  always_comb begin
    inew = iacc;
    if (ref_q == '0) inew = '0;
    if (inew > ilim) inew = ilim;
    else if (inew < -ilim) inew = -ilim;
  end

  always_comb begin
    if (trunc_q < 38'(min_step))                    step = 18'(min_step);
    else if (trunc_q > $signed({23'b0, max_step}))  step = $signed({3'b0, max_step});
    else                                            step = 18'(trunc_q);
    lvl = $signed({2'b0, duty_level}) + step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0; integral_sum <= '0; duty_level <= '0; dcnt <= '0;
    end else begin
      if (cmd.load) begin
        ref_q <= rate_ref; est_q <= rate_est; dt <= elapsed_ms;
      end
      if (cmd.err) begin
        err <= 17'($signed({1'b0, abs_ref}) - $signed({1'b0, abs_est}));
      end
      if (cmd.div_start) begin
        dneg <= diff[18];
        dnum <= diff[18] ? 18'(-diff) : 18'(diff);
        rem <= '0; quo <= '0; dcnt <= 5'(DivCnt + 1);
      end
      if (cmd.div_step && dcnt != '0) begin
        // restoring division, one quotient bit per cycle
        if (!rem_try[18]) begin rem <= rem_try[17:0]; quo <= {quo[16:0], 1'b1}; end
        else begin rem <= {rem[16:0], dnum[17]}; quo <= {quo[16:0], 1'b0}; end
        dnum <= {dnum[16:0], 1'b0};
        dcnt <= dcnt - 5'd1;
      end
      if (cmd.dsign) begin
        if (dt == '0) de <= '0;
        else de <= dneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        last_error <= err;
      end
      if (cmd.imul1) prod <= 34'(err * $signed({1'b0, dt}));
      if (cmd.imul2) iacc <= 52'(integral_sum) + 52'(prod) * $signed({1'b0, ki_gain});
      if (cmd.iclamp) begin
        integral_sum <= 32'(inew);
        prod <= 34'(err * $signed({1'b0, kp_gain}));
      end
      if (cmd.pmul) begin
        pterm <= prod;
        prod <= 34'(de * $signed({1'b0, kd_gain}));
      end
      if (cmd.dmul) total <= 54'(pterm) + 54'(prod) + 54'(integral_sum);
      // hold the truncated sum so the clamps start from a register
      if (cmd.sum) trunc_q <= trunc;
      if (cmd.level) begin
        pwm_step <= 16'(step);
        if (lvl < 0) duty_level <= '0;
        else if (lvl > $signed({2'b0, pwm_max})) duty_level <= pwm_max;
        else duty_level <= 16'(lvl);
      end
    end
  end

  assign stat.div_done = (dcnt == '0);
  assign pwm_level = duty_level;

endmodule

// ===== rtl/pid_rate_pwm_controller_core.sv =====
// Top level of the single-wheel PID speed controller with PWM accumulator.
//   channel   | dir | handshake              | payload
//   s_axis    | in  | s_axis_tvalid/tready   | rate_ref, rate_est, elapsed_ms
//   m_axis    | out | m_axis_tvalid/tready   | pwm_step, pwm_level
//   cfg       | in  | cfg_we                 | cfg_index, cfg_data
// Each item passes through the sequencer steps in order: the accept, the error step,
// the 18-step restoring divider for the derivative, the derivative sign, multiply, clamp,
// sum and level steps, and one output step that waits until the output register is free.
// Reset (rst, synchronous) restores register defaults and clears the state.
// Hold a finished result in the sequencer until the output register is free;
// take the next item only when the sequencer is idle again.
module pid_rate_pwm_controller_core import prpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // rate_ref[15:0], rate_est[31:16], elapsed_ms[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // pwm_step[15:0], pwm_level[31:16]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy, res_push, in_fire, out_free;

  logic [15:0]        kp_gain, ki_gain, kd_gain, pwm_max;
  logic [14:0]        integral_limit, max_step;
  logic signed [15:0] min_step;
  logic signed [15:0] pwm_step;
  logic [15:0]        pwm_level;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain <= 16'd256; ki_gain <= '0; kd_gain <= '0;
      integral_limit <= 15'd100; min_step <= -16'sd10; max_step <= 15'd10;
      pwm_max <= 16'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP:   kp_gain <= cfg_data;
        REG_KI:   ki_gain <= cfg_data;
        REG_KD:   kd_gain <= cfg_data;
        REG_ILIM: integral_limit <= cfg_data[14:0];
        REG_MINS: min_step <= cfg_data;
        REG_MAXS: max_step <= cfg_data[14:0];
        REG_PWMX: pwm_max <= cfg_data;
        default:  ;
      endcase
    end
  end

  assign s_axis_tready = !busy;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Output register: hold the result until taken.
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (res_push) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (res_push) m_axis_tdata <= {pwm_level, pwm_step};
  end

  prpc_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_free, .stat, .cmd, .busy, .res_push
  );

  prpc_dp u_dp (
    .clk, .rst, .cmd, .stat,
    .rate_ref(s_axis_tdata[15:0]), .rate_est(s_axis_tdata[31:16]),
    .elapsed_ms(s_axis_tdata[47:32]),
    .kp_gain, .ki_gain, .kd_gain, .integral_limit, .min_step, .max_step,
    .pwm_max, .pwm_step, .pwm_level
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready) else $error("item taken while busy");
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    res_push |-> out_free) else $error("result overwrote pending item");
  a_push_valid: assert property (@(posedge clk) disable iff (rst)
    res_push |=> m_axis_tvalid) else $error("result lost");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the wheel speed PID controller core.
`timescale 1ns / 1ps

class pwm_scoreboard;
  // controller settings and state, widths as in the block
  bit [15:0] kp, ki, kd, pmax;
  bit [14:0] ilim, smax;
  bit signed [15:0] smin;
  longint prev_err, integ, duty;
  bit [31:0] pending[$];
  int mismatches;
  int checked;

  function void clear();
    kp = 256; ki = 0; kd = 0; ilim = 100; smin = -10; smax = 10; pmax = 255;
    prev_err = 0; integ = 0; duty = 0;
    pending.delete();
  endfunction

  function void write_reg(bit [2:0] idx, bit [15:0] val);
    case (idx)
      prpc_pkg::REG_KP:   kp = val;
      prpc_pkg::REG_KI:   ki = val;
      prpc_pkg::REG_KD:   kd = val;
      prpc_pkg::REG_ILIM: ilim = val[14:0];
      prpc_pkg::REG_MINS: smin = val;
      prpc_pkg::REG_MAXS: smax = val[14:0];
      prpc_pkg::REG_PWMX: pmax = val;
      default: ;
    endcase
  endfunction

  // work out the step and level for one accepted item
  function void note_item(bit [47:0] d);
    longint r, m, t, err, de, lim, s, mag, stp, lvl;
    r = longint'($signed(d[15:0]));
    m = longint'($signed(d[31:16]));
    t = longint'(d[47:32]);
    err = (r < 0 ? -r : r) - (m < 0 ? -m : m);
    de = 0;
    if (t != 0) de = (err - prev_err) / t;
    lim = longint'(ilim) * 65536;
    if (r == 0) integ = 0;
    else integ += err * t * longint'(ki);
    if (integ < -lim) integ = -lim;
    else if (integ > lim) integ = lim;
    prev_err = err;
    s = err * longint'(kp) + de * longint'(kd) + integ;
    mag = (s < 0 ? -s : s) >>> 16;
    stp = s < 0 ? -mag : mag;
    // lower bound wins when min is above max
    if (stp < longint'(smin)) stp = smin;
    else if (stp > longint'(smax)) stp = smax;
    lvl = duty + stp;
    if (lvl < 0) lvl = 0;
    else if (lvl > longint'(pmax)) lvl = pmax;
    duty = lvl;
    pending.push_back({lvl[15:0], stp[15:0]});
  endfunction

  function void check_result(bit [31:0] got);
    bit [31:0] want;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (want[15:0] !== got[15:0] || want[31:16] !== got[31:16]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch #%0d: step exp %0d got %0d, level exp %0d got %0d", checked,
                 $signed(want[15:0]), $signed(got[15:0]), want[31:16], got[31:16]);
    end
  endfunction
endclass

module tb_top;
  import prpc_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // rate_ref[15:0], rate_est[31:16], elapsed_ms[47:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // pwm_step[15:0], pwm_level[31:16]
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  pwm_scoreboard sb;
  bit quiet_src;      // disable sender gaps
  bit quiet_sink;     // disable receiver stalls
  int hold_off;       // receiver hold-off length in cycles, applied once
  int n_items;

  pid_rate_pwm_controller_core i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog: well above the slowest legal run
  initial begin
    #40ms;
    $display("pid_rate_pwm_controller_core test failed");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_off > 0) begin
        m_axis_tready <= 0;
        hold_off--;
      end else begin
        m_axis_tready <= quiet_sink || ($urandom_range(99) >= 33);
      end
    end
  end

  // offer one item, holding valid until taken; random gap first
  task automatic send_item(bit [15:0] r, bit [15:0] m, bit [15:0] t);
    while (!quiet_src && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {t, m, r};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item({t, m, r});
    n_items++;
  endtask

  task automatic write_cfg(bit [2:0] idx, bit [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // drain all pending results before touching settings
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_cfg();
    write_cfg(REG_KP, $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(1023)));
    write_cfg(REG_KI, $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(63)));
    write_cfg(REG_KD, $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(2047)));
    write_cfg(REG_ILIM, $urandom_range(3) == 0 ? 16'h7FFF : 16'($urandom_range(500)));
    write_cfg(REG_MINS, $urandom_range(3) == 0 ? 16'h8000 : 16'(-$urandom_range(200)));
    write_cfg(REG_MAXS, $urandom_range(3) == 0 ? 16'h7FFF : 16'($urandom_range(200)));
    write_cfg(REG_PWMX, $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(4095)));
  endtask

  // random item: mostly modest rates and short steps, sometimes full range
  task automatic random_item();
    bit [15:0] r, m, t;
    r = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4096) - 2048);
    m = ($urandom_range(7) == 0) ? 16'($urandom) : 16'(r + $urandom_range(512) - 256);
    case ($urandom_range(9))
      0: t = 0;
      1: t = 16'($urandom);
      default: t = 16'($urandom_range(1, 20));
    endcase
    if ($urandom_range(19) == 0) r = 0;
    send_item(r, m, t);
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst = 1; s_axis_tvalid = 0; s_axis_tdata = '0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    quiet_src = 0; quiet_sink = 0; hold_off = 0; n_items = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset defaults, field extremes, zero elapsed, zero reference
    send_item(16'h0100, 16'h0000, 16'd1);
    send_item(16'h7FFF, 16'h8000, 16'd0);
    send_item(16'h8000, 16'h0000, 16'hFFFF);
    send_item(16'h0000, 16'h7FFF, 16'd5);
    send_item(16'hFFFF, 16'h0001, 16'd1);
    drain();
    write_cfg(REG_KP, 16'hFFFF); write_cfg(REG_KI, 16'hFFFF);
    write_cfg(REG_KD, 16'hFFFF); write_cfg(REG_ILIM, 16'h7FFF);
    write_cfg(REG_MINS, 16'h8000); write_cfg(REG_MAXS, 16'h7FFF);
    write_cfg(REG_PWMX, 16'hFFFF);
    write_cfg(3'd7, 16'h1234);  // unused index, must be ignored
    send_item(16'h7FFF, 16'h0000, 16'hFFFF);
    send_item(16'h7FFF, 16'h0000, 16'hFFFF);
    send_item(16'h8000, 16'h8000, 16'd3);
    send_item(16'h0000, 16'h8000, 16'd0);
    send_item(16'h0001, 16'h7FFF, 16'd1);
    send_item(16'h5555, 16'hAAAA, 16'hAAAA);
    drain();
    // zero limits first, then min above max: lower bound must win
    write_cfg(REG_MINS, 16'h0000); write_cfg(REG_MAXS, 16'h0000);
    write_cfg(REG_PWMX, 16'h0000); write_cfg(REG_ILIM, 16'h0000);
    send_item(16'h1000, 16'h0000, 16'd2);
    send_item(16'h0000, 16'h1000, 16'd2);
    drain();
    write_cfg(REG_MINS, 16'd5); write_cfg(REG_MAXS, 16'd2);
    write_cfg(REG_PWMX, 16'd100);
    send_item(16'h0000, 16'h1000, 16'd1);
    send_item(16'h1000, 16'h0000, 16'd1);
    send_item(16'h2000, 16'h2000, 16'd1);

    // random phases, new settings between them
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      random_cfg();
      quiet_src = (ph == 3); quiet_sink = (ph == 3);
      if (ph == 5) hold_off = 600;
      repeat (145) random_item();
    end
    quiet_src = 0; quiet_sink = 0;
    s_axis_tvalid <= 0;

    fork
      begin
        while (sb.pending.size() != 0) @(posedge clk);
      end
      begin
        repeat (200000) @(posedge clk);
      end
    join_any
    disable fork;
    repeat (60) @(posedge clk);
    $display("Covered %0d items over 10 random settings plus directed cases,", n_items);
    $display("%0d results checked, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("pid_rate_pwm_controller_core test passed");
    end else begin
      $display("pid_rate_pwm_controller_core test failed");
    end
    $finish;
  end
endmodule
